@@ rtl/core/gwef_pkg.sv @@
// ----------------------------------------------------------------------------
// gwef_pkg
// Shared types and constants of the gapped window energy filter core.
// ----------------------------------------------------------------------------
package gwef_pkg;

  localparam int VAL_W      = 24;
  localparam int SAMPLE_W   = 16;
  localparam int CNT_W      = 10;
  localparam int L_W        = 7;
  localparam int G_W        = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int DELAY_DEPTH_DEF = 512;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LENGTH    = CFG_IDX_W'(1);

  localparam logic [L_W-1:0]   WINDOW_RESET = L_W'(50);
  localparam logic [G_W-1:0]   GAP_RESET    = G_W'(50);
  localparam logic [CNT_W-1:0] COUNT_MAX    = '1;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_last;
  } in_item_t;

  typedef struct packed {
    val_t filter_value;
    logic filter_valid;
    val_t peak_value;
    logic frame_done;
  } out_item_t;

  // one classified sample with its delay line taps, zero where a tap is unused
  typedef struct packed {
    val_t x;
    val_t tap_late_out;
    val_t tap_early_in;
    val_t tap_early_out;
    logic valid;
    logic last;
  } work_item_t;

endpackage

@@ rtl/core/gwef_ram.sv @@
// ----------------------------------------------------------------------------
// gwef_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gwef_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/gwef_front.sv @@
// ----------------------------------------------------------------------------
// gwef_front
// Accepts samples, holds configuration, keeps the frame count, writes the
// delay line and reads the three window taps for each sample.
// ----------------------------------------------------------------------------
module gwef_front import gwef_pkg::*; #(
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  in_item_t              in_data,
  output logic                  in_full,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [QCNT_W-1:0]     q_count,
  output logic                  q_push,
  output work_item_t            q_entry
);

  localparam int AW = $clog2(DELAY_DEPTH);

  // value modulo the delay depth, by conditional subtraction of shifted depths
  function automatic logic [AW-1:0] wrap_depth(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    for (int k = CNT_W - 1; k >= 0; k--) begin
      if ((DELAY_DEPTH << k) < (1 << CNT_W)) begin
        if (r >= CNT_W'(DELAY_DEPTH << k)) begin
          r = r - CNT_W'(DELAY_DEPTH << k);
        end
      end
    end
    return AW'(r);
  endfunction

  function automatic logic [AW-1:0] tap_addr(input logic [AW-1:0] wp, input logic [AW-1:0] off);
    logic [AW:0] t;
    t = (AW+1)'(wp) + (AW+1)'(DELAY_DEPTH) - (AW+1)'(off);
    if (t >= (AW+1)'(DELAY_DEPTH)) begin
      t = t - (AW+1)'(DELAY_DEPTH);
    end
    return t[AW-1:0];
  endfunction

  localparam logic [CNT_W-1:0] RST_THR_A = CNT_W'(WINDOW_RESET) + CNT_W'(1);
  localparam logic [CNT_W-1:0] RST_THR_B = CNT_W'(WINDOW_RESET) + CNT_W'(GAP_RESET);
  localparam logic [CNT_W-1:0] RST_THR_F = CNT_W'({WINDOW_RESET, 1'b0}) + CNT_W'(GAP_RESET);
  localparam logic [AW-1:0]    RST_OFF_A = wrap_depth(RST_THR_A);
  localparam logic [AW-1:0]    RST_OFF_B = wrap_depth(RST_THR_B);
  localparam logic [AW-1:0]    RST_OFF_C = wrap_depth(RST_THR_F + CNT_W'(1));

  logic [L_W-1:0]   l_r, l_nxt;
  logic [G_W-1:0]   g_r, g_nxt;
  logic [CNT_W-1:0] thr_a_r, thr_b_r, thr_f_r;
  logic [CNT_W-1:0] thr_a_nxt, thr_b_nxt, thr_f_nxt;
  logic [AW-1:0]    off_a_r, off_b_r, off_c_r;

  logic [CNT_W-1:0] cnt_r;
  logic [AW-1:0]    wp_r, wp_nxt;
  logic             acc;

  logic [VAL_W-1:0]       raw;
  logic [SAMPLE_BITS-1:0] xs;
  val_t                   x_ext;

  logic [AW-1:0]          addr_a, addr_b, addr_c;
  logic [SAMPLE_BITS-1:0] rd_a, rd_b, rd_c;

  logic p_v_r;
  val_t p_x_r;
  logic p_last_r, p_valid_r;
  logic p_use_a_r, p_use_b_r, p_use_c_r;
  logic p_byp_a_r, p_byp_b_r, p_byp_c_r;

  // configuration
  always_comb begin
    l_nxt = l_r;
    g_nxt = g_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: l_nxt = cfg_wdata[L_W-1:0];
        REG_GAP_LENGTH:    g_nxt = cfg_wdata[G_W-1:0];
        default: ;
      endcase
    end
    thr_a_nxt = CNT_W'(l_nxt) + CNT_W'(1);
    thr_b_nxt = CNT_W'(l_nxt) + CNT_W'(g_nxt);
    thr_f_nxt = CNT_W'({l_nxt, 1'b0}) + CNT_W'(g_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_r     <= WINDOW_RESET;
      g_r     <= GAP_RESET;
      thr_a_r <= RST_THR_A;
      thr_b_r <= RST_THR_B;
      thr_f_r <= RST_THR_F;
      off_a_r <= RST_OFF_A;
      off_b_r <= RST_OFF_B;
      off_c_r <= RST_OFF_C;
    end else begin
      l_r     <= l_nxt;
      g_r     <= g_nxt;
      thr_a_r <= thr_a_nxt;
      thr_b_r <= thr_b_nxt;
      thr_f_r <= thr_f_nxt;
      off_a_r <= wrap_depth(thr_a_nxt);
      off_b_r <= wrap_depth(thr_b_nxt);
      off_c_r <= wrap_depth(thr_f_nxt + CNT_W'(1));
    end
  end

  // accept and address
  assign in_full = (QCNT_W'(q_count) + QCNT_W'(p_v_r)) >= QCNT_W'(QUEUE_DEPTH);
  assign acc     = in_push && !in_full;

  assign wp_nxt = (wp_r == AW'(DELAY_DEPTH - 1)) ? '0 : wp_r + AW'(1);
  assign addr_a = tap_addr(wp_nxt, off_a_r);
  assign addr_b = tap_addr(wp_nxt, off_b_r);
  assign addr_c = tap_addr(wp_nxt, off_c_r);

  assign raw   = VAL_W'($unsigned(in_data.sample));
  assign xs    = raw[SAMPLE_BITS-1:0];
  assign x_ext = VAL_W'($signed(xs));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= '0;
      p_v_r <= 1'b0;
    end else begin
      p_v_r <= acc;
      if (acc) begin
        wp_r <= wp_nxt;
        if (in_data.frame_last) begin
          cnt_r <= '0;
        end else if (cnt_r != COUNT_MAX) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p_x_r     <= x_ext;
      p_last_r  <= in_data.frame_last;
      p_valid_r <= cnt_r >= thr_f_r;
      p_use_a_r <= cnt_r >= thr_a_r;
      p_use_b_r <= cnt_r >= thr_b_r;
      p_use_c_r <= cnt_r > thr_f_r;
      p_byp_a_r <= off_a_r == '0;
      p_byp_b_r <= off_b_r == '0;
      p_byp_c_r <= off_c_r == '0;
    end
  end

  // one copy of the delay line for each tap
  gwef_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DELAY_DEPTH)) u_ram_a (
    .clk(clk), .we(acc), .waddr(wp_nxt), .wdata(xs), .raddr(addr_a), .rdata(rd_a)
  );

  gwef_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DELAY_DEPTH)) u_ram_b (
    .clk(clk), .we(acc), .waddr(wp_nxt), .wdata(xs), .raddr(addr_b), .rdata(rd_b)
  );

  gwef_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DELAY_DEPTH)) u_ram_c (
    .clk(clk), .we(acc), .waddr(wp_nxt), .wdata(xs), .raddr(addr_c), .rdata(rd_c)
  );

  // tap at a multiple of the depth is the sample itself
  always_comb begin
    q_entry.x             = p_x_r;
    q_entry.tap_late_out  = '0;
    q_entry.tap_early_in  = '0;
    q_entry.tap_early_out = '0;
    if (p_use_a_r) begin
      q_entry.tap_late_out = p_byp_a_r ? p_x_r : VAL_W'($signed(rd_a));
    end
    if (p_use_b_r) begin
      q_entry.tap_early_in = p_byp_b_r ? p_x_r : VAL_W'($signed(rd_b));
    end
    if (p_use_c_r) begin
      q_entry.tap_early_out = p_byp_c_r ? p_x_r : VAL_W'($signed(rd_c));
    end
    q_entry.valid = p_valid_r;
    q_entry.last  = p_last_r;
  end

  assign q_push = p_v_r;

endmodule

@@ rtl/core/gwef_queue.sv @@
// ----------------------------------------------------------------------------
// gwef_queue
// Short register queue between the front and the back of the filter.
// ----------------------------------------------------------------------------
module gwef_queue import gwef_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  work_item_t        push_data,
  input  logic              pop,
  output work_item_t        head,
  output logic              empty,
  output logic [QCNT_W-1:0] count
);

  work_item_t        slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head  = slot_r[rd_ptr_r];
  assign empty = count_r == '0;
  assign count = count_r;

endmodule

@@ rtl/core/gwef_back.sv @@
// ----------------------------------------------------------------------------
// gwef_back
// Window sums, filter difference and frame peak, ending in the result register.
// ----------------------------------------------------------------------------
module gwef_back import gwef_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  work_item_t q_head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output out_item_t  out_data
);

  val_t late_r, early_r;
  val_t late_nxt, early_nxt;
  val_t peak_r, peak_nxt;
  logic seen_r;

  logic s1_v_r, s1_valid_r, s1_last_r;
  val_t s1_late_r, s1_early_r;

  logic s2_v_r, s2_valid_r, s2_last_r;
  val_t s2_value_r;

  logic      out_v_r;
  out_item_t out_data_r;

  logic s1_rdy, s2_rdy, s3_rdy;
  logic take_peak;

  assign s3_rdy = !out_v_r || out_pop;
  assign s2_rdy = !s2_v_r || s3_rdy;
  assign s1_rdy = !s1_v_r || s2_rdy;
  assign q_pop  = !q_empty && s1_rdy;

  assign late_nxt  = late_r + q_head.x - q_head.tap_late_out;
  assign early_nxt = early_r + q_head.tap_early_in - q_head.tap_early_out;

  assign take_peak = s2_valid_r && (!seen_r || (s2_value_r > peak_r));
  assign peak_nxt  = take_peak ? s2_value_r : peak_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      late_r  <= '0;
      early_r <= '0;
      peak_r  <= VAL_MIN;
      seen_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_r <= q_pop;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_rdy) begin
        out_v_r <= s2_v_r;
      end
      if (q_pop) begin
        late_r  <= q_head.last ? '0 : late_nxt;
        early_r <= q_head.last ? '0 : early_nxt;
      end
      if (s3_rdy && s2_v_r) begin
        peak_r <= s2_last_r ? VAL_MIN : peak_nxt;
        seen_r <= s2_last_r ? 1'b0 : (seen_r || s2_valid_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_late_r  <= late_nxt;
      s1_early_r <= early_nxt;
      s1_valid_r <= q_head.valid;
      s1_last_r  <= q_head.last;
    end
    if (s2_rdy && s1_v_r) begin
      s2_value_r <= s1_valid_r ? (s1_late_r - s1_early_r) : '0;
      s2_valid_r <= s1_valid_r;
      s2_last_r  <= s1_last_r;
    end
    if (s3_rdy && s2_v_r) begin
      out_data_r.filter_value <= s2_value_r;
      out_data_r.filter_valid <= s2_valid_r;
      out_data_r.peak_value   <= peak_nxt;
      out_data_r.frame_done   <= s2_last_r;
    end
  end

  assign out_empty = !out_v_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/core/gapped_window_energy_filter_core.sv @@
// ----------------------------------------------------------------------------
// gapped_window_energy_filter_core
// Trapezoidal pulse shaping filter with per-frame peak (energy) detection.
// ----------------------------------------------------------------------------
// Takes one sample per clock while in_full is low and gives one result per
// sample, in order. Each result passes the stage that reads the three window
// taps, then the queue, the window sums, the late minus early difference and
// the peak stage, and leaves in the result register. The rate of one sample
// per cycle comes from three copies of the delay line RAM, one read port per
// tap, each written with every sample. The delay line needs no clearing pass
// after reset; samples are accepted from the first cycle. A full output
// stalls the back first and then the front through the four entry queue.
// Write window and gap lengths only while no samples are in flight.
// ----------------------------------------------------------------------------
module gapped_window_energy_filter_core import gwef_pkg::*; #(
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  in_item_t              in_data,
  output logic                  in_full,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic              q_push, q_pop, q_empty;
  logic [QCNT_W-1:0] q_count;
  work_item_t        q_entry, q_head;

  gwef_front #(
    .DELAY_DEPTH(DELAY_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  gwef_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_entry),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .count     (q_count)
  );

  gwef_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
